/* rtl/core/utcc_pkg.sv */
// Shared types, constants and calendar helper functions for the epoch
// seconds to Gregorian calendar converter. No dependencies.
`timescale 1ns / 1ps

package utcc_pkg;

	localparam int SEC_W  = 36;
	localparam int ACC_W  = 38;
	localparam int YEAR_W = 12;
	localparam int CNT_W  = 6;

	localparam logic [YEAR_W-1:0] YEAR_MAX    = 12'd4095;
	localparam logic [YEAR_W-1:0] EPOCH_RESET = 12'd1970;
	localparam logic [SEC_W-1:0]  SECONDS_MAX = 36'hF_FFFF_FFFF;

	localparam logic [ACC_W-1:0] SECS_DAY  = 38'd86400;
	localparam logic [ACC_W-1:0] SECS_HOUR = 38'd3600;
	localparam logic [ACC_W-1:0] SECS_MIN  = 38'd60;

	localparam logic [ACC_W-1:0] SECS_YEAR_366 = 38'd31622400;
	localparam logic [ACC_W-1:0] SECS_YEAR_365 = 38'd31536000;
	localparam logic [ACC_W-1:0] SECS_MON_31   = 38'd2678400;
	localparam logic [ACC_W-1:0] SECS_MON_30   = 38'd2592000;
	localparam logic [ACC_W-1:0] SECS_MON_29   = 38'd2505600;
	localparam logic [ACC_W-1:0] SECS_MON_28   = 38'd2419200;

	localparam int CENTURIES = 41;

	typedef struct packed {
		logic              action;
		logic [SEC_W-1:0]  seconds;
		logic [YEAR_W-1:0] year;
		logic [3:0]        month;
		logic [4:0]        day;
		logic [4:0]        hour;
		logic [5:0]        minute;
		logic [5:0]        second;
	} item_t;

	typedef struct packed {
		logic [SEC_W-1:0]  seconds;
		logic [YEAR_W-1:0] year;
		logic [3:0]        month;
		logic [4:0]        day;
		logic [4:0]        hour;
		logic [5:0]        minute;
		logic [5:0]        second;
		logic              out_of_range;
	} res_t;

	typedef struct packed {
		logic idle;
		logic done;
	} ctrl_stat_t;

	typedef struct packed {
		logic [ACC_W-1:0] sum;
		logic             ge;
	} alu_res_t;

	// True for every multiple of 100 that fits in a 12-bit year.
	function automatic logic is_century(input logic [YEAR_W-1:0] y);
		logic r;
		r = 1'b0;
		for (int k = 0; k < CENTURIES; k++) begin
			if (y == YEAR_W'(k * 100))
				r = 1'b1;
		end
		return r;
	endfunction

	// A century year that is also a multiple of 16 is a multiple of 400.
	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		return (y[1:0] == 2'b00) && (!is_century(y) || (y[3:0] == 4'b0000));
	endfunction

	function automatic logic [ACC_W-1:0] year_secs(input logic [YEAR_W-1:0] y);
		return is_leap(y) ? SECS_YEAR_366 : SECS_YEAR_365;
	endfunction

	// Month index 0 is January.
	function automatic logic [ACC_W-1:0] month_secs(input logic [3:0] m, input logic leap);
		logic [ACC_W-1:0] r;
		unique case (m)
			4'd1:                      r = leap ? SECS_MON_29 : SECS_MON_28;
			4'd3, 4'd5, 4'd8, 4'd10:   r = SECS_MON_30;
			default:                   r = SECS_MON_31;
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/utcc_alu.sv */
// Shared 38-bit add/subtract unit with a no-borrow flag for compares.
// Depends on utcc_pkg.
`timescale 1ns / 1ps

module utcc_alu
	import utcc_pkg::*;
(
	input  logic [ACC_W-1:0] a,
	input  logic [ACC_W-1:0] b,
	input  logic             sub,
	output alu_res_t         res
);

	logic [ACC_W-1:0] b_eff;
	logic [ACC_W:0]   total;

	assign b_eff = sub ? ~b : b;
	assign total = {1'b0, a} + {1'b0, b_eff} + {{ACC_W{1'b0}}, sub};

	// On a subtraction the carry out is set when a >= b.
	assign res.sum = total[ACC_W-1:0];
	assign res.ge  = total[ACC_W];

endmodule

/* rtl/core/utcc_ctrl.sv */
// Sequencer and datapath registers that walk years, months, days, hours and
// minutes through the shared add/subtract unit. Depends on utcc_pkg, utcc_alu.
`timescale 1ns / 1ps

module utcc_ctrl
	import utcc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  item_t             item,
	input  logic [YEAR_W-1:0] epoch_base,
	input  logic              take,
	output ctrl_stat_t        stat,
	output res_t              res
);

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_TS_YEAR  = 4'd1;
	localparam logic [3:0] ST_TS_MONTH = 4'd2;
	localparam logic [3:0] ST_TS_DAY   = 4'd3;
	localparam logic [3:0] ST_TS_HOUR  = 4'd4;
	localparam logic [3:0] ST_TS_MIN   = 4'd5;
	localparam logic [3:0] ST_TS_SEC   = 4'd6;
	localparam logic [3:0] ST_FS_YEAR  = 4'd7;
	localparam logic [3:0] ST_FS_MONTH = 4'd8;
	localparam logic [3:0] ST_FS_DAY   = 4'd9;
	localparam logic [3:0] ST_FS_HOUR  = 4'd10;
	localparam logic [3:0] ST_FS_MIN   = 4'd11;
	localparam logic [3:0] ST_DONE     = 4'd12;

	logic [3:0]        state_q, state_d;
	item_t             item_q;
	item_t             item_fold;
	logic [ACC_W-1:0]  acc_q;
	logic [YEAR_W-1:0] yr_q;
	logic [3:0]        mon_q;
	logic [CNT_W-1:0]  cnt_q;
	res_t              res_q;

	logic [ACC_W-1:0]  op_b;
	logic              op_sub;
	alu_res_t          alu;

	logic yr_more, mon_more, cnt_nz, fs_mon_stop, sat;

	utcc_alu u_alu (
		.a   (acc_q),
		.b   (op_b),
		.sub (op_sub),
		.res (alu)
	);

	assign yr_more     = yr_q < item_q.year;
	assign mon_more    = (mon_q + 4'd1) < item_q.month;
	assign cnt_nz      = cnt_q != '0;
	assign fs_mon_stop = (mon_q == 4'd11) || !alu.ge;
	assign sat         = alu.sum[ACC_W-1:SEC_W] != '0;

	// Out-of-range months and day zero are folded in here.
	always_comb begin
		item_fold = item;
		if (item.month == 4'd0)
			item_fold.month = 4'd1;
		else if (item.month > 4'd12)
			item_fold.month = 4'd12;
		if (item.day == 5'd0)
			item_fold.day = 5'd1;
	end

	always_comb begin
		op_b   = '0;
		op_sub = 1'b0;
		unique case (state_q)
			ST_TS_YEAR:  op_b = year_secs(yr_q);
			ST_TS_MONTH: op_b = month_secs(mon_q, is_leap(item_q.year));
			ST_TS_DAY:   op_b = SECS_DAY;
			ST_TS_HOUR:  op_b = SECS_HOUR;
			ST_TS_MIN:   op_b = SECS_MIN;
			ST_TS_SEC:   op_b = ACC_W'(item_q.second);
			ST_FS_YEAR: begin
				op_b   = year_secs(yr_q);
				op_sub = 1'b1;
			end
			ST_FS_MONTH: begin
				op_b   = month_secs(mon_q, is_leap(yr_q));
				op_sub = 1'b1;
			end
			ST_FS_DAY: begin
				op_b   = SECS_DAY;
				op_sub = 1'b1;
			end
			ST_FS_HOUR: begin
				op_b   = SECS_HOUR;
				op_sub = 1'b1;
			end
			ST_FS_MIN: begin
				op_b   = SECS_MIN;
				op_sub = 1'b1;
			end
			default: begin
				op_b   = '0;
				op_sub = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (start) state_d = item.action ? ST_FS_YEAR : ST_TS_YEAR;
			ST_TS_YEAR:  if (!yr_more) state_d = ST_TS_MONTH;
			ST_TS_MONTH: if (!mon_more) state_d = ST_TS_DAY;
			ST_TS_DAY:   if (!cnt_nz) state_d = ST_TS_HOUR;
			ST_TS_HOUR:  if (!cnt_nz) state_d = ST_TS_MIN;
			ST_TS_MIN:   if (!cnt_nz) state_d = ST_TS_SEC;
			ST_TS_SEC:   state_d = ST_DONE;
			ST_FS_YEAR: begin
				if (!alu.ge)
					state_d = ST_FS_MONTH;
				else if (yr_q == YEAR_MAX)
					state_d = ST_DONE;
			end
			ST_FS_MONTH: if (fs_mon_stop) state_d = ST_FS_DAY;
			ST_FS_DAY:   if (!alu.ge) state_d = ST_FS_HOUR;
			ST_FS_HOUR:  if (!alu.ge) state_d = ST_FS_MIN;
			ST_FS_MIN:   if (!alu.ge) state_d = ST_DONE;
			ST_DONE:     if (take) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					item_q <= item_fold;
					acc_q  <= item.action ? ACC_W'(item.seconds) : '0;
					yr_q   <= epoch_base;
					mon_q  <= 4'd0;
					cnt_q  <= '0;
				end
			end
			ST_TS_YEAR: begin
				if (yr_more) begin
					acc_q <= alu.sum;
					yr_q  <= yr_q + 12'd1;
				end
			end
			ST_TS_MONTH: begin
				if (mon_more) begin
					acc_q <= alu.sum;
					mon_q <= mon_q + 4'd1;
				end else begin
					cnt_q <= CNT_W'(item_q.day - 5'd1);
				end
			end
			ST_TS_DAY: begin
				if (cnt_nz) begin
					acc_q <= alu.sum;
					cnt_q <= cnt_q - 6'd1;
				end else begin
					cnt_q <= CNT_W'(item_q.hour);
				end
			end
			ST_TS_HOUR: begin
				if (cnt_nz) begin
					acc_q <= alu.sum;
					cnt_q <= cnt_q - 6'd1;
				end else begin
					cnt_q <= item_q.minute;
				end
			end
			ST_TS_MIN: begin
				if (cnt_nz) begin
					acc_q <= alu.sum;
					cnt_q <= cnt_q - 6'd1;
				end
			end
			ST_TS_SEC: begin
				res_q.seconds      <= sat ? SECONDS_MAX : alu.sum[SEC_W-1:0];
				res_q.year         <= '0;
				res_q.month        <= '0;
				res_q.day          <= '0;
				res_q.hour         <= '0;
				res_q.minute       <= '0;
				res_q.second       <= '0;
				res_q.out_of_range <= sat;
			end
			ST_FS_YEAR: begin
				if (alu.ge) begin
					if (yr_q == YEAR_MAX) begin
						res_q.seconds      <= '0;
						res_q.year         <= YEAR_MAX;
						res_q.month        <= 4'd12;
						res_q.day          <= 5'd31;
						res_q.hour         <= 5'd23;
						res_q.minute       <= 6'd59;
						res_q.second       <= 6'd59;
						res_q.out_of_range <= 1'b1;
					end else begin
						acc_q <= alu.sum;
						yr_q  <= yr_q + 12'd1;
					end
				end
			end
			ST_FS_MONTH: begin
				if (fs_mon_stop) begin
					cnt_q <= '0;
				end else begin
					acc_q <= alu.sum;
					mon_q <= mon_q + 4'd1;
				end
			end
			ST_FS_DAY: begin
				if (alu.ge) begin
					acc_q <= alu.sum;
					cnt_q <= cnt_q + 6'd1;
				end else begin
					res_q.day <= 5'(cnt_q + 6'd1);
					cnt_q     <= '0;
				end
			end
			ST_FS_HOUR: begin
				if (alu.ge) begin
					acc_q <= alu.sum;
					cnt_q <= cnt_q + 6'd1;
				end else begin
					res_q.hour <= 5'(cnt_q);
					cnt_q      <= '0;
				end
			end
			ST_FS_MIN: begin
				if (alu.ge) begin
					acc_q <= alu.sum;
					cnt_q <= cnt_q + 6'd1;
				end else begin
					res_q.seconds      <= '0;
					res_q.year         <= yr_q;
					res_q.month        <= mon_q + 4'd1;
					res_q.minute       <= cnt_q;
					res_q.second       <= acc_q[5:0];
					res_q.out_of_range <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	assign stat.idle = state_q == ST_IDLE;
	assign stat.done = state_q == ST_DONE;
	assign res       = res_q;

endmodule

/* rtl/core/unix_time_calendar_converter.sv */
// Calendar to seconds adds whole years from the epoch year up to year_in, then months, days,
// hours, minutes and second_in; seconds to calendar subtracts years, months, days, hours and
// minutes in turn and keeps the remainder as second_out.
// One item at a time: every step goes through the single shared add/subtract unit.
// A new item is taken while the previous result waits in the output register.
// arst_n clears the control state and the output valid, and sets the epoch year to 1970.
`timescale 1ns / 1ps

module unix_time_calendar_converter
	import utcc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [11:0] cfg_data,   // epoch year
	input  logic        s_tvalid,
	output logic        s_tready,
	// seconds_in[35:0], year_in[47:36], month_in[51:48], day_in[56:52],
	// hour_in[61:57], minute_in[67:62], second_in[73:68], zero fill [79:74]
	input  logic [79:0] s_tdata,
	input  logic        s_tuser,    // action
	output logic        m_tvalid,
	input  logic        m_tready,
	// seconds_out[35:0], year_out[47:36], month_out[51:48], day_out[56:52],
	// hour_out[61:57], minute_out[67:62], second_out[73:68], zero fill [79:74]
	output logic [79:0] m_tdata,
	output logic        m_tuser     // out_of_range
);

	logic [YEAR_W-1:0] epoch_q;
	item_t             item;
	ctrl_stat_t        stat;
	res_t              res;
	res_t              out_q;
	logic              out_valid_q;
	logic              load;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q <= EPOCH_RESET;
		end else if (cfg_valid) begin
			epoch_q <= cfg_data;
		end
	end

	assign item.action  = s_tuser;
	assign item.seconds = s_tdata[35:0];
	assign item.year    = s_tdata[47:36];
	assign item.month   = s_tdata[51:48];
	assign item.day     = s_tdata[56:52];
	assign item.hour    = s_tdata[61:57];
	assign item.minute  = s_tdata[67:62];
	assign item.second  = s_tdata[73:68];

	assign s_tready = stat.idle;

	// The finished result moves to the output register once that is free.
	assign load = stat.done && (!out_valid_q || m_tready);

	utcc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (s_tvalid && s_tready),
		.item       (item),
		.epoch_base (epoch_q),
		.take       (load),
		.stat       (stat),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, out_q.second, out_q.minute, out_q.hour, out_q.day,
		out_q.month, out_q.year, out_q.seconds};
	assign m_tuser  = out_q.out_of_range;

endmodule

/* verif/unix_time_calendar_converter_tb.sv */
// Self-checking testbench for unix_time_calendar_converter: directed corner dates,
// then random conversions under several epoch settings, checked by a scoreboard.
// Depends on utcc_pkg and the converter RTL only.
`timescale 1ns / 1ps

module unix_time_calendar_converter_tb;
	import utcc_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES    = 300;
	localparam int RANDOM_ITEMS   = 100;

	class calendar_scoreboard;
		int unsigned epoch;
		int unsigned mismatches;
		res_t        due_results[$];
		int unsigned month_table[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

		function new();
			epoch = EPOCH_RESET;
			mismatches = 0;
		endfunction

		function void set_epoch(logic [YEAR_W-1:0] value);
			epoch = value;
		endfunction

		function int unsigned pending();
			return due_results.size();
		endfunction

		function bit leap_year(int unsigned y);
			if (y % 4 != 0)
				return 1'b0;
			if (y % 100 != 0)
				return 1'b1;
			return (y % 400) == 0;
		endfunction

		// Leap years in [0, y).
		function longint unsigned leaps_below(int unsigned y);
			return longint'((y + 3) / 4) - longint'((y + 99) / 100) + longint'((y + 399) / 400);
		endfunction

		// Month index 0 is January.
		function longint unsigned month_days(int unsigned m, int unsigned y);
			if (m == 1)
				return leap_year(y) ? 29 : 28;
			return month_table[m % 12];
		endfunction

		function longint unsigned days_in_year(int unsigned y);
			return leap_year(y) ? 366 : 365;
		endfunction

		function res_t predict_conversion(item_t it);
			res_t              r;
			longint unsigned   days;
			longint unsigned   total;
			longint unsigned   rem;
			longint unsigned   span;
			int unsigned       y;
			int unsigned       m;
			int unsigned       d;
			r = '0;
			if (!it.action) begin
				y = it.year;
				m = it.month;
				d = it.day;
				if (m == 0)
					m = 1;
				if (m > 12)
					m = 12;
				if (d == 0)
					d = 1;
				days = 0;
				if (y > epoch)
					days = 365 * longint'(y - epoch) + leaps_below(y) - leaps_below(epoch);
				for (int unsigned i = 0; i + 1 < m; i++)
					days += month_days(i, y);
				days += d - 1;
				total = days * SECS_DAY + 64'(it.hour) * SECS_HOUR + 64'(it.minute) * SECS_MIN
					+ 64'(it.second);
				if (total > 64'(SECONDS_MAX)) begin
					total = SECONDS_MAX;
					r.out_of_range = 1'b1;
				end
				r.seconds = total[SEC_W-1:0];
			end else begin
				rem = it.seconds;
				y = epoch;
				forever begin
					span = days_in_year(y) * SECS_DAY;
					if (rem < span)
						break;
					// Walking past the last representable year pins the result.
					if (y >= YEAR_MAX) begin
						r.year = YEAR_MAX;
						r.month = 4'd12;
						r.day = 5'd31;
						r.hour = 5'd23;
						r.minute = 6'd59;
						r.second = 6'd59;
						r.out_of_range = 1'b1;
						return r;
					end
					rem -= span;
					y++;
				end
				for (m = 0; m < 11; m++) begin
					span = month_days(m, y) * SECS_DAY;
					if (rem < span)
						break;
					rem -= span;
				end
				r.year = y[YEAR_W-1:0];
				r.month = 4'(m + 1);
				r.day = 5'(rem / SECS_DAY + 1);
				rem = rem % SECS_DAY;
				r.hour = 5'(rem / SECS_HOUR);
				rem = rem % SECS_HOUR;
				r.minute = 6'(rem / SECS_MIN);
				r.second = 6'(rem % SECS_MIN);
			end
			return r;
		endfunction

		function void note_item(item_t it);
			due_results.push_back(predict_conversion(it));
		endfunction

		function void compare_field(string name, longint unsigned want, longint unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (due_results.size() == 0) begin
				$error("result transaction with no conversion outstanding");
				mismatches++;
				return;
			end
			want = due_results.pop_front();
			compare_field("seconds_out", want.seconds, got.seconds);
			compare_field("year_out", want.year, got.year);
			compare_field("month_out", want.month, got.month);
			compare_field("day_out", want.day, got.day);
			compare_field("hour_out", want.hour, got.hour);
			compare_field("minute_out", want.minute, got.minute);
			compare_field("second_out", want.second, got.second);
			compare_field("out_of_range", want.out_of_range, got.out_of_range);
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [11:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic        m_tuser;

	calendar_scoreboard sb;
	bit                 idling_on = 1'b1;
	bit                 hold_req = 1'b0;
	int                 quiet_cycles = 0;

	unix_time_calendar_converter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [79:0] pack_item(item_t it);
		return {6'b0, it.second, it.minute, it.hour, it.day, it.month, it.year, it.seconds};
	endfunction

	function automatic res_t unpack_result(logic [79:0] d, logic flag);
		res_t r;
		r.seconds = d[35:0];
		r.year = d[47:36];
		r.month = d[51:48];
		r.day = d[56:52];
		r.hour = d[61:57];
		r.minute = d[67:62];
		r.second = d[73:68];
		r.out_of_range = flag;
		return r;
	endfunction

	function automatic item_t calendar_item(int unsigned y, int unsigned mo, int unsigned d,
		int unsigned h, int unsigned mi, int unsigned s);
		item_t it;
		it.action = 1'b0;
		it.seconds = 36'($urandom());
		it.year = 12'(y);
		it.month = 4'(mo);
		it.day = 5'(d);
		it.hour = 5'(h);
		it.minute = 6'(mi);
		it.second = 6'(s);
		return it;
	endfunction

	// Mostly dates close to the epoch so the year walk stays short.
	function automatic item_t random_item(int unsigned epoch);
		item_t it;
		int    yr;
		int    pick;
		it.action = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 99);
		if (pick < 5)
			it.seconds = 36'({4'($urandom_range(0, 15)), $urandom()});
		else if (pick < 15)
			it.seconds = 36'($urandom_range(0, 200000));
		else
			it.seconds = 36'($urandom());
		if ($urandom_range(0, 99) < 5) begin
			it.year = 12'($urandom());
		end else begin
			yr = int'(epoch) + int'($urandom_range(0, 150)) - 20;
			if (yr < 0)
				yr = 0;
			if (yr > 4095)
				yr = 4095;
			it.year = 12'(yr);
		end
		it.month = ($urandom_range(0, 9) == 0) ? 4'($urandom()) : 4'($urandom_range(1, 12));
		it.day = ($urandom_range(0, 7) == 0) ? 5'($urandom()) : 5'($urandom_range(1, 28));
		it.hour = ($urandom_range(0, 9) == 0) ? 5'($urandom()) : 5'($urandom_range(0, 23));
		it.minute = ($urandom_range(0, 9) == 0) ? 6'($urandom()) : 6'($urandom_range(0, 59));
		it.second = ($urandom_range(0, 9) == 0) ? 6'($urandom()) : 6'($urandom_range(0, 59));
		return it;
	endfunction

	// Called and returns at a falling edge; tvalid stays high for a following item.
	task automatic send_item(item_t it);
		while (idling_on && $urandom_range(0, 99) < 13) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = pack_item(it);
		s_tuser = it.action;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_item(it);
		@(negedge clk);
	endtask

	// Sends a calendar date and then its predicted second count back the other way.
	task automatic send_round_trip(item_t cal);
		item_t back;
		back = cal;
		back.action = 1'b1;
		back.seconds = sb.predict_conversion(cal).seconds;
		send_item(cal);
		send_item(back);
	endtask

	// The last second of year 4095 and the one after it, where the year walk saturates.
	task automatic send_year_limit();
		item_t cal;
		item_t beyond;
		cal = calendar_item(4095, 12, 31, 23, 59, 59);
		send_round_trip(cal);
		beyond = cal;
		beyond.action = 1'b1;
		beyond.seconds = sb.predict_conversion(cal).seconds + 36'd1;
		send_item(beyond);
		beyond.seconds = SECONDS_MAX;
		send_item(beyond);
	endtask

	task automatic send_random(int n);
		repeat (n)
			send_item(random_item(sb.epoch));
		s_tvalid = 1'b0;
	endtask

	task automatic drain();
		s_tvalid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	task automatic write_epoch(logic [11:0] value);
		cfg_valid = 1'b1;
		cfg_data = value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_epoch(value);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready = 1'b0;
				repeat (HOLD_CYCLES)
					@(negedge clk);
			end
			m_tready = !(idling_on && $urandom_range(0, 99) < 13);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(unpack_result(m_tdata, m_tuser));
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
			|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[unix_time_calendar_converter] ERROR");
				$finish;
			end
		end
	end

	initial begin
		int unsigned epochs[6];
		sb = new();
		epochs = '{1, 4095, 2000, 1600, $urandom_range(1, 4095), 1970};
		repeat (12)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset epoch: leap rules, years before the epoch, out-of-range fields.
		send_round_trip(calendar_item(1970, 1, 1, 0, 0, 0));
		send_round_trip(calendar_item(2000, 2, 29, 12, 34, 56));
		send_round_trip(calendar_item(2100, 3, 1, 0, 0, 0));
		send_round_trip(calendar_item(1969, 12, 31, 23, 59, 59));
		send_round_trip(calendar_item(0, 3, 1, 0, 0, 0));
		send_round_trip(calendar_item(2024, 0, 0, 0, 0, 0));
		send_round_trip(calendar_item(2023, 13, 31, 31, 63, 63));
		send_round_trip(calendar_item(4095, 15, 31, 23, 59, 59));
		send_round_trip(calendar_item(2038, 1, 19, 3, 14, 7));
		send_year_limit();

		// The receiver stalls for a long stretch while items keep coming.
		hold_req = 1'b1;
		send_random(RANDOM_ITEMS);

		foreach (epochs[k]) begin
			drain();
			write_epoch(12'(epochs[k]));
			idling_on = (epochs[k] != 2000);
			send_item(calendar_item(epochs[k], 1, 1, 0, 0, 0));
			send_year_limit();
			send_random(RANDOM_ITEMS);
		end

		drain();
		repeat (50)
			@(posedge clk);
		if (sb.mismatches == 0)
			$display("[unix_time_calendar_converter] OK");
		else
			$display("[unix_time_calendar_converter] ERROR");
		$finish;
	end

endmodule
